// File: rtl/circle_rasterizer_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the circle rasterizer core
// Concurrent checks clocked on aclk, disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef CIRCLE_RASTERIZER_CORE_ASSERT_SVH
`define CIRCLE_RASTERIZER_CORE_ASSERT_SVH

// same-cycle implication
`define CRAST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CRAST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/crast_pkg.sv
// ---------------------------------------------------------------------------
// crast_pkg
// Shared types and constants of the circle rasterizer core.
// ---------------------------------------------------------------------------
`default_nettype none

package crast_pkg;

    localparam int COORD_BITS_DEF = 14;
    localparam int DEC_BITS       = 20;

    // item kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // group sizes
    localparam int IDX_BITS        = 3;
    localparam int POINTS_PER_GRP  = 8;
    localparam int SPANS_PER_GRP   = 4;

    localparam int QUEUE_DEPTH = 2;

    // per-group control carried with each queued step
    typedef struct packed {
        logic fill;
        logic done;
    } crast_ctl_t;

endpackage

`default_nettype wire

// File: rtl/crast_front.sv
// ---------------------------------------------------------------------------
// crast_front
// Decodes start/advance items, runs one midpoint step per advance while a
// circle is active and pushes the resulting group descriptor into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module crast_front #(
    parameter int COORD_BITS = crast_pkg::COORD_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_accept,
    input  wire logic                    in_kind,
    input  wire logic [COORD_BITS-1:0]   in_cx,
    input  wire logic [COORD_BITS-1:0]   in_cy,
    input  wire logic [COORD_BITS-2:0]   in_radius,
    input  wire logic                    in_fill,
    output logic                         push,
    output logic [COORD_BITS-1:0]        push_cx,
    output logic [COORD_BITS-1:0]        push_cy,
    output logic [COORD_BITS-1:0]        push_x,
    output logic [COORD_BITS-1:0]        push_y,
    output crast_pkg::crast_ctl_t        push_ctl,
    output logic                         active
);
    import crast_pkg::*;

    localparam int EW = COORD_BITS + DEC_BITS;

    logic [COORD_BITS-1:0] cx_reg, cy_reg, x_reg, y_reg;
    logic [COORD_BITS-1:0] cx_next, cy_next, x_next, y_next;
    logic [DEC_BITS-1:0]   dec_reg, dec_next;
    logic                  fill_reg, fill_next;
    logic                  active_reg, active_next;

    logic signed [EW-1:0]  xs, ys, ds, x1, y1, dsum, dstart;
    logic                  d_pos, step_done;

    function automatic logic [DEC_BITS-1:0] dsum_start(input logic signed [EW-1:0] v);
        dsum_start = v[DEC_BITS-1:0];
    endfunction

    always_comb begin
        xs     = {{(EW-COORD_BITS){x_reg[COORD_BITS-1]}}, x_reg};
        ys     = {{(EW-COORD_BITS){y_reg[COORD_BITS-1]}}, y_reg};
        ds     = {{(EW-DEC_BITS){dec_reg[DEC_BITS-1]}}, dec_reg};
        d_pos  = ($signed(dec_reg) > 0);
        x1     = xs + EW'(1);
        y1     = d_pos ? ys - EW'(1) : ys;
        dsum   = d_pos ? ds + ((x1 - y1) <<< 2) + EW'(10)
                       : ds + (x1 <<< 2) + EW'(6);
        dstart = EW'(3) - ({{(EW-COORD_BITS+1){1'b0}}, in_radius} <<< 1);
        step_done = ($signed(y1[COORD_BITS-1:0]) < $signed(x1[COORD_BITS-1:0]));
    end

    always_comb begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        dec_next    = dec_reg;
        fill_next   = fill_reg;
        active_next = active_reg;
        push        = 1'b0;
        push_ctl    = '{fill: fill_reg, done: 1'b0};
        if (in_accept) begin
            if (in_kind == KIND_START) begin
                cx_next     = in_cx;
                cy_next     = in_cy;
                x_next      = '0;
                y_next      = {1'b0, in_radius};
                dec_next    = dsum_start(dstart);
                fill_next   = in_fill;
                active_next = 1'b1;
                push        = 1'b1;
                push_ctl    = '{fill: in_fill, done: 1'b0};
            end else if (active_reg) begin
                x_next      = x1[COORD_BITS-1:0];
                y_next      = y1[COORD_BITS-1:0];
                dec_next    = dsum[DEC_BITS-1:0];
                active_next = !step_done;
                push        = 1'b1;
                push_ctl    = '{fill: fill_reg, done: step_done};
            end
        end
        push_cx = cx_next;
        push_cy = cy_next;
        push_x  = x_next;
        push_y  = y_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            dec_reg    <= '0;
            fill_reg   <= 1'b0;
            active_reg <= 1'b0;
        end else begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            dec_reg    <= dec_next;
            fill_reg   <= fill_next;
            active_reg <= active_next;
        end
    end

    assign active = active_reg;

endmodule

`default_nettype wire

// File: rtl/crast_queue.sv
// ---------------------------------------------------------------------------
// crast_queue
// Small register FIFO of group descriptors between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module crast_queue #(
    parameter int COORD_BITS = crast_pkg::COORD_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire logic [COORD_BITS-1:0]   push_cx,
    input  wire logic [COORD_BITS-1:0]   push_cy,
    input  wire logic [COORD_BITS-1:0]   push_x,
    input  wire logic [COORD_BITS-1:0]   push_y,
    input  wire crast_pkg::crast_ctl_t   push_ctl,
    output logic                         full,
    input  wire logic                    pop,
    output logic                         head_valid,
    output logic [COORD_BITS-1:0]        head_cx,
    output logic [COORD_BITS-1:0]        head_cy,
    output logic [COORD_BITS-1:0]        head_x,
    output logic [COORD_BITS-1:0]        head_y,
    output crast_pkg::crast_ctl_t        head_ctl,
    output logic [$clog2(crast_pkg::QUEUE_DEPTH+1)-1:0] level
);
    import crast_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH+1);
    localparam int EB = 4*COORD_BITS + $bits(crast_ctl_t);

    logic [EB-1:0] mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full       = (cnt_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign level      = cnt_reg;
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    assign {head_cx, head_cy, head_x, head_y, head_ctl} = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= {push_cx, push_cy, push_x, push_y, push_ctl};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/crast_back.sv
// ---------------------------------------------------------------------------
// crast_back
// Expands the head group descriptor into points or spans, one per cycle
// while out_ready is high and a descriptor is queued, through a registered output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module crast_back #(
    parameter int COORD_BITS = crast_pkg::COORD_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    head_valid,
    input  wire logic [COORD_BITS-1:0]   head_cx,
    input  wire logic [COORD_BITS-1:0]   head_cy,
    input  wire logic [COORD_BITS-1:0]   head_x,
    input  wire logic [COORD_BITS-1:0]   head_y,
    input  wire crast_pkg::crast_ctl_t   head_ctl,
    output logic                         pop,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [COORD_BITS:0]          out_pos_x,
    output logic [COORD_BITS:0]          out_pos_y,
    output logic [COORD_BITS:0]          out_end_x,
    output logic                         out_is_span,
    output logic                         out_last,
    output logic                         out_done
);
    import crast_pkg::*;

    localparam int OW = COORD_BITS + 1;

    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic                valid_reg, valid_next;
    logic [OW-1:0]       px_reg, py_reg, ex_reg;
    logic                span_reg, last_reg, done_reg;

    logic                load, is_last, sel_swap, neg_h, neg_v;
    logic signed [OW-1:0] cx_e, cy_e, h_e, v_e, cx_p, cx_m, cy_p, cy_m;
    logic [OW-1:0]       px_c, py_c, ex_c;

    always_comb begin
        if (head_ctl.fill) begin
            // spans: rows at +-y use x half-width, rows at +-x use y
            sel_swap = idx_reg[1];
            neg_v    = idx_reg[0];
            neg_h    = 1'b1;
            is_last  = (idx_reg == IDX_BITS'(SPANS_PER_GRP-1));
        end else begin
            sel_swap = idx_reg[2];
            neg_v    = idx_reg[1];
            neg_h    = idx_reg[0];
            is_last  = (idx_reg == IDX_BITS'(POINTS_PER_GRP-1));
        end
        cx_e = {head_cx[COORD_BITS-1], head_cx};
        cy_e = {head_cy[COORD_BITS-1], head_cy};
        h_e  = sel_swap ? {head_y[COORD_BITS-1], head_y} : {head_x[COORD_BITS-1], head_x};
        v_e  = sel_swap ? {head_x[COORD_BITS-1], head_x} : {head_y[COORD_BITS-1], head_y};
        cx_p = cx_e + h_e;
        cx_m = cx_e - h_e;
        cy_p = cy_e + v_e;
        cy_m = cy_e - v_e;
        px_c = neg_h ? cx_m : cx_p;
        py_c = neg_v ? cy_m : cy_p;
        ex_c = head_ctl.fill ? cx_p : px_c;
    end

    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && is_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = is_last ? '0 : idx_reg + 1'b1;
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            px_reg   <= px_c;
            py_reg   <= py_c;
            ex_reg   <= ex_c;
            span_reg <= head_ctl.fill;
            last_reg <= is_last;
            done_reg <= head_ctl.done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_pos_x   = px_reg;
    assign out_pos_y   = py_reg;
    assign out_end_x   = ex_reg;
    assign out_is_span = span_reg;
    assign out_last    = last_reg;
    assign out_done    = done_reg;

endmodule

`default_nettype wire

// File: rtl/circle_rasterizer_core.sv
// ---------------------------------------------------------------------------
// circle_rasterizer_core
// Midpoint circle generator: start/advance items in, points or spans out.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake           contents
//  s_*       in   s_tvalid/s_tready   start or advance item, kind on tuser
//  m_*       out  m_tvalid/m_tready   point or span beat, group end on tlast
//
//  Each accepted item yields one group: 8 point beats in outline mode,
//  4 span beats in fill mode, one beat per cycle from the output register
//  while m_tready is high; an advance after the circle ended yields nothing.
//  Throughput is bound by the single back-end expansion unit. Front step
//  logic takes an item per cycle while the 2-entry group queue has room,
//  so it runs ahead of the back end.
//  Reset (aresetn low, synchronous) clears state, queue and output valid.
//  m_tready low stalls the back end; s_tready drops only when the queue fills.
//
`default_nettype none

module circle_rasterizer_core #(
    parameter int COORD_BITS = crast_pkg::COORD_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input item
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // tdata: center_x, center_y, radius, fill_mode (zero padded to bytes)
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    // tuser: kind
    input  wire logic                                s_tuser,
    // result beat
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // tdata: pos_x, pos_y, end_x (zero padded to bytes)
    output logic [((3*(COORD_BITS+1)+7)/8)*8-1:0]    m_tdata,
    // tuser: is_span, circle_done
    output logic [1:0]                               m_tuser,
    // tlast: last_in_group
    output logic                                     m_tlast
);
    import crast_pkg::*;

    `include "circle_rasterizer_core_assert.svh"

    localparam int OUT_W = ((3*(COORD_BITS+1)+7)/8)*8;

    logic                  s_accept;
    logic                  push, full, pop, head_valid, active;
    logic [COORD_BITS-1:0] push_cx, push_cy, push_x, push_y;
    logic [COORD_BITS-1:0] head_cx, head_cy, head_x, head_y;
    crast_ctl_t            push_ctl, head_ctl;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;
    logic [COORD_BITS:0]   pos_x, pos_y, end_x;
    logic                  is_span, circle_done;

    assign s_tready = !full;
    assign s_accept = s_tvalid && s_tready;

    // front: decode and step
    crast_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_accept),
        .in_kind   (s_tuser),
        .in_cx     (s_tdata[COORD_BITS-1:0]),
        .in_cy     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_radius (s_tdata[3*COORD_BITS-2:2*COORD_BITS]),
        .in_fill   (s_tdata[3*COORD_BITS-1]),
        .push      (push),
        .push_cx   (push_cx),
        .push_cy   (push_cy),
        .push_x    (push_x),
        .push_y    (push_y),
        .push_ctl  (push_ctl),
        .active    (active)
    );

    // group descriptors waiting for expansion
    crast_queue #(.COORD_BITS(COORD_BITS)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cx    (push_cx),
        .push_cy    (push_cy),
        .push_x     (push_x),
        .push_y     (push_y),
        .push_ctl   (push_ctl),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cx    (head_cx),
        .head_cy    (head_cy),
        .head_x     (head_x),
        .head_y     (head_y),
        .head_ctl   (head_ctl),
        .level      (q_level)
    );

    // back: one beat per cycle while m_tready is high
    crast_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head_cx     (head_cx),
        .head_cy     (head_cy),
        .head_x      (head_x),
        .head_y      (head_y),
        .head_ctl    (head_ctl),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_pos_x   (pos_x),
        .out_pos_y   (pos_y),
        .out_end_x   (end_x),
        .out_is_span (is_span),
        .out_last    (m_tlast),
        .out_done    (circle_done)
    );

    assign m_tdata = OUT_W'({end_x, pos_y, pos_x});
    assign m_tuser = {circle_done, is_span};

    // a group streams without gaps once its first beat is out
    `CRAST_ASSERT_NXT(a_group_no_gap, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid, "group beat gap")

    // points carry identical ends
    `CRAST_ASSERT_IMP(a_point_ends, aclk, aresetn, m_tvalid && !is_span, pos_x == end_x, "point end_x mismatch")

    // advance with no circle running leaves the queue untouched
    `CRAST_ASSERT_IMP(a_idle_advance, aclk, aresetn, s_accept && (s_tuser == KIND_ADVANCE) && !active, !push, "idle advance pushed a group")

    // ready reflects queue occupancy
    `CRAST_ASSERT_IMP(a_ready_level, aclk, aresetn, !s_tready, q_level == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH), "ready low without full queue")

endmodule

`default_nettype wire

// File: tb/circle_rasterizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_rasterizer_core_tb
// Self-checking bench for the midpoint circle generator. Start and advance
// beats go in on the s_ side. A cycle-free model of the circle walk predicts
// every point or span beat, and each beat on the m_ side is checked against it
// field by field. Both sides idle at random. One long receiver stall fills the
// core so that it has to hold off its input.
// ----------------------------------------------------------------------------
module circle_rasterizer_core_tb;

    import crast_pkg::*;

    localparam int CB         = COORD_BITS_DEF;           // centre / step width
    localparam int OW         = CB + 1;                   // output coordinate width
    localparam int SW         = ((3*CB+7)/8)*8;           // s_tdata width
    localparam int MW         = ((3*(CB+1)+7)/8)*8;       // m_tdata width
    localparam int RAND_ITEMS = 110;
    localparam int LONG_HOLD  = 300;                      // cycles of receiver stall
    localparam int DRAIN      = 40;                       // cycles allowed after last beat

    // one expected output beat
    typedef struct {
        logic signed [OW-1:0] pos_x;
        logic signed [OW-1:0] pos_y;
        logic signed [OW-1:0] end_x;
        logic                 is_span;
        logic                 last_in_group;
        logic                 circle_done;
    } raster_beat_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [SW-1:0] s_tdata;
    logic          s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [MW-1:0] m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tlast;

    // predicted circle state, at the core's own widths
    logic signed [CB-1:0]       ctr_col;
    logic signed [CB-1:0]       ctr_row;
    logic signed [CB-1:0]       walk_x;
    logic signed [CB-1:0]       walk_y;
    logic signed [DEC_BITS-1:0] walk_d;
    logic                       fill_on;
    logic                       tracing;

    raster_beat_t pending_beats[$];

    int  error_count;
    int  items_sent;
    int  circles_started;
    int  beats_checked;
    int  stall_cycles;
    bit  no_idle;
    bit  hold_req;

    circle_rasterizer_core #(
        .COORD_BITS (CB)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // generous cap on simulation time
    initial begin
        #(64'd20_000_000);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Gap lengths: mostly none or short, now and then a long one
    // ------------------------------------------------------------------------
    function automatic int idle_len();
        int p;
        p = $urandom_range(99);
        if (no_idle || p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // tdata layout, low bit up: center_x, center_y, radius, fill_mode, zero pad
    function automatic logic [SW-1:0] pack_item(logic [CB-1:0] cx, logic [CB-1:0] cy,
                                                logic [CB-2:0] r, logic fill);
        logic [SW-1:0] w;
        w = '0;
        w[3*CB-1:0] = {fill, r, cy, cx};
        return w;
    endfunction

    // advance beats carry don't-care payload; keep it random
    function automatic logic [SW-1:0] junk_payload();
        return pack_item(CB'($urandom), CB'($urandom), (CB-1)'($urandom), 1'($urandom));
    endfunction

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    task automatic add_beat(input int px, input int py, input int ex,
                            input logic span, input logic last, input logic done);
        raster_beat_t b;
        b.pos_x         = px[OW-1:0];
        b.pos_y         = py[OW-1:0];
        b.end_x         = ex[OW-1:0];
        b.is_span       = span;
        b.last_in_group = last;
        b.circle_done   = done;
        pending_beats.push_back(b);
    endtask

    // one group for the current (x, y): eight octant points or four spans
    task automatic queue_group(input logic done);
        int cx, cy, x, y;
        cx = int'(ctr_col);
        cy = int'(ctr_row);
        x  = int'(walk_x);
        y  = int'(walk_y);
        if (fill_on) begin
            add_beat(cx - x, cy + y, cx + x, 1'b1, 1'b0, done);
            add_beat(cx - x, cy - y, cx + x, 1'b1, 1'b0, done);
            add_beat(cx - y, cy + x, cx + y, 1'b1, 1'b0, done);
            add_beat(cx - y, cy - x, cx + y, 1'b1, 1'b1, done);
        end else begin
            add_beat(cx + x, cy + y, cx + x, 1'b0, 1'b0, done);
            add_beat(cx - x, cy + y, cx - x, 1'b0, 1'b0, done);
            add_beat(cx + x, cy - y, cx + x, 1'b0, 1'b0, done);
            add_beat(cx - x, cy - y, cx - x, 1'b0, 1'b0, done);
            add_beat(cx + y, cy + x, cx + y, 1'b0, 1'b0, done);
            add_beat(cx - y, cy + x, cx - y, 1'b0, 1'b0, done);
            add_beat(cx + y, cy - x, cx + y, 1'b0, 1'b0, done);
            add_beat(cx - y, cy - x, cx - y, 1'b0, 1'b1, done);
        end
    endtask

    // circle walk for one accepted item
    task automatic trace_circle(input logic kind, input logic [SW-1:0] data);
        int   r, x, y, d;
        logic done;
        if (kind == KIND_START) begin
            r       = int'(data[3*CB-2:2*CB]);
            ctr_col = data[CB-1:0];
            ctr_row = data[2*CB-1:CB];
            fill_on = data[3*CB-1];
            walk_x  = '0;
            walk_y  = CB'(r);
            walk_d  = DEC_BITS'(3 - 2*r);
            tracing = 1'b1;
            queue_group(1'b0);
        end else if (tracing) begin
            x = int'(walk_x) + 1;
            y = int'(walk_y);
            d = int'(walk_d);
            if (d > 0) begin
                y = y - 1;
                d = d + 4*(x - y) + 10;
            end else begin
                d = d + 4*x + 6;
            end
            walk_x = CB'(x);
            walk_y = CB'(y);
            walk_d = DEC_BITS'(d);
            done   = walk_y < walk_x;
            if (done)
                tracing = 1'b0;
            queue_group(done);
        end
        // advance with no circle running: nothing comes out
    endtask

    // ------------------------------------------------------------------------
    // Input side: one beat per call, valid stays up across back-to-back beats
    // ------------------------------------------------------------------------
    task automatic send_item(input logic kind, input logic [SW-1:0] data);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do
            @(posedge aclk);
        while (!s_tready);
        trace_circle(kind, data);
        items_sent++;
    endtask

    task automatic send_start(input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                              input logic [CB-2:0] r, input logic fill);
        circles_started++;
        send_item(KIND_START, pack_item(cx, cy, r, fill));
    endtask

    task automatic send_advance(input int n);
        repeat (n) send_item(KIND_ADVANCE, junk_payload());
    endtask

    // ------------------------------------------------------------------------
    // Output side: random ready, plus one long hold on request
    // ------------------------------------------------------------------------
    initial begin : ready_gen
        int n;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (n = 1; n < LONG_HOLD; n++)
                    @(posedge aclk);
            end else if (no_idle || $urandom_range(99) < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                n = idle_len();
                repeat (n) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk)
        if (aresetn && s_tvalid && !s_tready)
            stall_cycles++;

    // m_tdata low bit up: pos_x, pos_y, end_x; m_tuser: is_span, circle_done
    always @(posedge aclk) begin : beat_check
        raster_beat_t         want;
        logic signed [OW-1:0] got_px, got_py, got_ex;
        if (aresetn && m_tvalid && m_tready) begin
            got_px = m_tdata[OW-1:0];
            got_py = m_tdata[2*OW-1:OW];
            got_ex = m_tdata[3*OW-1:2*OW];
            if (pending_beats.size() == 0) begin
                $error("unexpected beat: pos_x %0d pos_y %0d end_x %0d",
                       got_px, got_py, got_ex);
                error_count++;
            end else begin
                want = pending_beats.pop_front();
                beats_checked++;
                if (got_px !== want.pos_x) begin
                    $error("pos_x: expected %0d, got %0d", want.pos_x, got_px);
                    error_count++;
                end
                if (got_py !== want.pos_y) begin
                    $error("pos_y: expected %0d, got %0d", want.pos_y, got_py);
                    error_count++;
                end
                if (got_ex !== want.end_x) begin
                    $error("end_x: expected %0d, got %0d", want.end_x, got_ex);
                    error_count++;
                end
                if (m_tuser[0] !== want.is_span) begin
                    $error("is_span: expected %0b, got %0b", want.is_span, m_tuser[0]);
                    error_count++;
                end
                if (m_tlast !== want.last_in_group) begin
                    $error("last_in_group: expected %0b, got %0b",
                           want.last_in_group, m_tlast);
                    error_count++;
                end
                if (m_tuser[1] !== want.circle_done) begin
                    $error("circle_done: expected %0b, got %0b",
                           want.circle_done, m_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // advance straight out of reset must produce nothing
    task automatic test_idle_advance();
        send_advance(2);
    endtask

    // radius zero: start group at the centre, first advance ends the circle,
    // a further advance is ignored
    task automatic test_zero_radius();
        send_start(14'sd100, -14'sd50, 13'd0, 1'b0);
        send_advance(2);
        send_start(-14'sd7, 14'sd3, 13'd0, 1'b1);
        send_advance(2);
    endtask

    // coordinate and radius extremes in both modes, and a tiny circle walked out
    task automatic test_extremes();
        send_start(-14'sd8192, 14'sd8191, 13'd8191, 1'b0);
        send_advance(3);
        send_start(14'sd8191, -14'sd8192, 13'd8191, 1'b1);
        send_advance(3);
        send_start(14'sd0, 14'sd0, 13'd1, 1'b1);
        while (tracing)
            send_advance(1);
        send_advance(1);
    endtask

    // a start in the middle of a running circle replaces it
    task automatic test_restart();
        send_start(14'sd200, 14'sd300, 13'd10, 1'b0);
        send_advance(2);
        send_start(-14'sd400, 14'sd25, 13'd5, 1'b1);
        while (tracing)
            send_advance(1);
    endtask

    // receiver parks for a long stretch while advances keep coming
    task automatic test_backpressure();
        no_idle = 1'b1;
        send_start(14'sd1000, -14'sd1000, 13'd40, 1'b0);
        hold_req = 1'b1;
        send_advance(12);
        no_idle = 1'b0;
    endtask

    // mostly complete circles with random centre, size and mode; some
    // abandoned part way, some advances past the end, some stray advances
    task automatic test_random_circles();
        int  first, steps;
        bit  big;
        first = items_sent;
        while (items_sent - first < RAND_ITEMS) begin
            no_idle = ($urandom_range(99) < 20);
            if ($urandom_range(99) < 12) begin
                send_advance(1);
            end else begin
                big = ($urandom_range(99) < 10);
                send_start(CB'($urandom), CB'($urandom),
                           big ? (CB-1)'($urandom_range(0, 8191))
                               : (CB-1)'($urandom_range(0, 24)),
                           1'($urandom_range(1)));
                if (big || $urandom_range(99) < 15)
                    steps = $urandom_range(0, 4);
                else
                    steps = 1 << 20;
                while (tracing && steps > 0) begin
                    send_advance(1);
                    steps--;
                end
                if (!tracing)
                    send_advance($urandom_range(0, 1));
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        error_count     = 0;
        items_sent      = 0;
        circles_started = 0;
        beats_checked   = 0;
        stall_cycles    = 0;
        no_idle         = 1'b0;
        hold_req        = 1'b0;
        ctr_col         = '0;
        ctr_row         = '0;
        walk_x          = '0;
        walk_y          = '0;
        walk_d          = '0;
        fill_on         = 1'b0;
        tracing         = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= KIND_START;
        s_tdata  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_advance();
        test_zero_radius();
        test_extremes();
        test_restart();
        test_backpressure();
        test_random_circles();

        // last beat was taken at this edge; drop valid before the next one
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge aclk);
        // catch any stray beat after the last expected one
        repeat (DRAIN) @(posedge aclk);

        $display("covered %0d items, %0d circles, %0d beats checked",
                 items_sent, circles_started, beats_checked);
        $display("input held off for %0d cycles", stall_cycles);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
